[rtl/dbq_pkg.sv]
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared types and constants for the bounded deque with reverse.
// ----------------------------------------------------------------------------
package dbq_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 6;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_UPDATE     = 3'd4,
    OP_REVERSE    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch item, compute slot, start memory read
    logic commit;  // apply item to state, load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

[rtl/dbq_ctrl.sv]
// ----------------------------------------------------------------------------
// dbq_ctrl
// Handshake sequencer: takes one item, waits for the result slot, commits.
// ----------------------------------------------------------------------------
module dbq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output dbq_pkg::dp_cmd_t    cmd
);

  dbq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      dbq_pkg::S_IDLE: begin
        // refuse items while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = dbq_pkg::S_EXEC;
        end
      end
      dbq_pkg::S_EXEC: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dbq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dbq_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/dbq_datapath.sv]
// ----------------------------------------------------------------------------
// dbq_datapath
// Ring store, front pointer, count, direction flag and result register.
// ----------------------------------------------------------------------------
module dbq_datapath #(
  parameter int DEPTH = dbq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dbq_pkg::dp_cmd_t                    cmd,
  input  logic [dbq_pkg::OP_W-1:0]            opcode,
  input  logic signed [dbq_pkg::WORD_W-1:0]   value,
  input  logic [dbq_pkg::POS_W-1:0]           position,
  output logic [dbq_pkg::STATUS_W-1:0]        status,
  output logic signed [dbq_pkg::WORD_W-1:0]   value_out,
  output dbq_pkg::dp_status_t                 dp_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [dbq_pkg::WORD_W-1:0] mem_r [DEPTH];
  logic [dbq_pkg::WORD_W-1:0] rd_data_r;

  logic [AW-1:0] front_r;
  logic [CW-1:0] count_r;
  logic          rev_r;

  // latched item
  dbq_pkg::op_t            op_r;
  dbq_pkg::status_t        st_r;
  logic                    at_start_r;
  logic [AW-1:0]           addr_r;
  logic [dbq_pkg::WORD_W-1:0] val_r;

  logic [dbq_pkg::STATUS_W-1:0] res_status_r;
  logic [dbq_pkg::WORD_W-1:0]   res_value_r;

  dbq_pkg::op_t     op_in;
  dbq_pkg::status_t st_calc;
  logic             at_start_calc;
  logic [AW-1:0]    addr_calc;
  logic [AW-1:0]    off;
  logic [AW:0]      sum;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    prev_front;
  logic [AW-1:0]    next_front;
  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    rev_off;

  assign op_in      = dbq_pkg::op_t'(opcode);
  assign count_m1   = count_r - CW'(1);
  assign rev_off    = count_m1 - CW'(position);
  assign prev_front = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign next_front = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);

  // offset from the ring start, then wrap once
  always_comb begin
    off = '0;
    unique case (op_in)
      dbq_pkg::OP_PUSH_FRONT,
      dbq_pkg::OP_PUSH_BACK: off = count_r[AW-1:0];
      dbq_pkg::OP_POP_FRONT,
      dbq_pkg::OP_POP_BACK:  off = count_m1[AW-1:0];
      dbq_pkg::OP_UPDATE:    off = rev_r ? rev_off[AW-1:0] : AW'(position);
      default:               off = '0;
    endcase
  end

  assign sum  = {1'b0, front_r} + {1'b0, off};
  assign slot = (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : sum[AW-1:0];

  always_comb begin
    st_calc       = dbq_pkg::STAT_OK;
    at_start_calc = 1'b0;
    addr_calc     = slot;
    unique case (op_in)
      dbq_pkg::OP_PUSH_FRONT,
      dbq_pkg::OP_PUSH_BACK: begin
        at_start_calc = (op_in == dbq_pkg::OP_PUSH_FRONT) != rev_r;
        if (count_r == DEPTH_C) st_calc = dbq_pkg::STAT_FULL;
        addr_calc = at_start_calc ? prev_front : slot;
      end
      dbq_pkg::OP_POP_FRONT,
      dbq_pkg::OP_POP_BACK: begin
        at_start_calc = (op_in == dbq_pkg::OP_POP_FRONT) != rev_r;
        if (count_r == '0) st_calc = dbq_pkg::STAT_EMPTY;
        addr_calc = at_start_calc ? front_r : slot;
      end
      dbq_pkg::OP_UPDATE: begin
        if (32'(position) >= 32'(count_r)) st_calc = dbq_pkg::STAT_NOTFOUND;
      end
      dbq_pkg::OP_REVERSE: begin
        if (count_r < CW'(2)) st_calc = dbq_pkg::STAT_EMPTY;
      end
      default: st_calc = dbq_pkg::STAT_OK;
    endcase
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op_in;
      st_r       <= st_calc;
      at_start_r <= at_start_calc;
      addr_r     <= addr_calc;
      val_r      <= value;
    end
  end

  // store: read on load, write on commit
  always_ff @(posedge clk) begin
    if (cmd.load) rd_data_r <= mem_r[addr_calc];
    if (cmd.commit && st_r == dbq_pkg::STAT_OK &&
        (op_r == dbq_pkg::OP_PUSH_FRONT || op_r == dbq_pkg::OP_PUSH_BACK ||
         op_r == dbq_pkg::OP_UPDATE))
      mem_r[addr_r] <= val_r;
  end

  // ring pointers and direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd.commit && st_r == dbq_pkg::STAT_OK) begin
      unique case (op_r)
        dbq_pkg::OP_PUSH_FRONT,
        dbq_pkg::OP_PUSH_BACK: begin
          if (at_start_r) front_r <= addr_r;
          count_r <= count_r + CW'(1);
        end
        dbq_pkg::OP_POP_FRONT,
        dbq_pkg::OP_POP_BACK: begin
          if (at_start_r) front_r <= next_front;
          count_r <= count_m1;
        end
        dbq_pkg::OP_REVERSE: rev_r <= !rev_r;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= st_r;
      res_value_r  <= '0;
      if (st_r == dbq_pkg::STAT_OK) begin
        unique case (op_r)
          dbq_pkg::OP_PUSH_FRONT,
          dbq_pkg::OP_PUSH_BACK,
          dbq_pkg::OP_UPDATE:   res_value_r <= val_r;
          dbq_pkg::OP_POP_FRONT,
          dbq_pkg::OP_POP_BACK: res_value_r <= rd_data_r;
          default:              res_value_r <= '0;
        endcase
      end
    end
  end

  assign status          = res_status_r;
  assign value_out       = res_value_r;
  assign dp_status.empty = (count_r == '0);
  assign dp_status.full  = (count_r == DEPTH_C);

endmodule

[rtl/bounded_deque_with_reverse_unit.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse_unit
// Bounded deque of signed words in a ring, with push, pop, update, reverse.
// ----------------------------------------------------------------------------
//  channel | ports                     | tdata fields, lowest bit first
//  input   | in_tvalid/tready/tdata    | opcode[2:0] value[34:3] position[40:35]
//  result  | out_tvalid/tready/tdata   | status[1:0] value_out[33:2]
//
//  Each item is first latched and its ring slot read, then committed
//  to the ring pointers and the result register in the EXEC state.
//  The ring read data is registered between the two steps.
//  A new item is taken while the previous result waits; commit holds
//  until the result register is free.
//  rst_n clears pointers, count, direction and the handshake state;
//  ring contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_reverse_unit #(
  parameter int DEPTH = dbq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // opcode[2:0], value[34:3], position[40:35], zero pad
  input  logic [dbq_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], value_out[33:2], zero pad
  output logic [dbq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  dbq_pkg::dp_cmd_t                   cmd;
  dbq_pkg::dp_status_t                dp_st;
  logic [dbq_pkg::STATUS_W-1:0]       status;
  logic signed [dbq_pkg::WORD_W-1:0]  value_out;

  dbq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dbq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .opcode    (in_tdata[2:0]),
    .value     (in_tdata[34:3]),
    .position  (in_tdata[40:35]),
    .status    (status),
    .value_out (value_out),
    .dp_status (dp_st)
  );

  assign out_tdata = {6'd0, value_out, status};

  // one item at a time: accept closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("commit did not present a result");

  a_full_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dp_st.full) |-> $past(cmd.commit))
    else $error("ring became full without a commit");

  a_fill_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(dp_st.empty) |-> $past(cmd.commit))
    else $error("ring left empty without a commit");

endmodule
